// ----- sv/fire_permission_gate_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FIRE_PERMISSION_GATE_DEFINES_SVH
`define FIRE_PERMISSION_GATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fire_permission_gate: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fire_permission_gate: check failed");

`endif

// ----- sv/fpg_pkg.sv -----
package fpg_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 23;

    localparam logic [CfgIdxW-1:0] CFG_SHOOT_EN       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLDOFF_EN     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLDOFF_FRAMES = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_NEAR_TOL       = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FAR_TOL        = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_JUDGE_DIST     = 3'd5;

    localparam int YawW    = 32;
    localparam int PosW    = 24;
    localparam int IdW     = 8;
    localparam int FrameW  = 8;
    localparam int TolW    = 20;
    localparam int DistW   = 23;
    localparam int SqW     = 2 * PosW - 1;   // square of a signed value is non-negative
    localparam int Dist2W  = SqW + 1;
    localparam int Judge2W = 2 * DistW;
    localparam int DiffW   = YawW + 1;

    localparam logic [FrameW-1:0] HOLDOFF_RESET = 8'd2;

    typedef struct packed {
        logic              shoot_en;
        logic              holdoff_en;
        logic [FrameW-1:0] holdoff_frames;
    } front_cfg_t;

    typedef struct packed {
        logic [TolW-1:0]    near_tol;
        logic [TolW-1:0]    far_tol;
        logic [Judge2W-1:0] judge2;
    } back_cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic             kill;       // gate closed or hold-off: fire forced low
        logic             aim_valid;
        logic [SqW-1:0]   x2;
        logic [SqW-1:0]   y2;
        logic [DiffW-1:0] dcmd;       // |previous_yaw - command_yaw|
        logic [DiffW-1:0] dgim;       // |gimbal_yaw - previous_yaw|
    } work_t;

endpackage

// ----- sv/fire_permission_gate.sv -----
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------------
// input    | in_valid / in_stall | control_on has_target command_yaw gimbal_yaw
//          |                     | pos_x pos_y target_id aim_valid
// output   | out_valid/out_stall | fire
// config   | cfg_we              | cfg_index cfg_data
//
// One word per cycle sustained while out_stall is low. A taken word passes the
// front register, the queue and the output register before out_valid/fire
// show it, and it leaves once out_stall is low.
// Throughput is set by the front stage: squares, yaw differences and the
// hold-off state update all finish in the cycle a word is accepted.
// Reset (rst_n, async, low) clears the tracked yaw, id and hold-off state,
// empties the queue and returns config to defaults (holdoff_frames = 2).
// An output stall fills the queue; in_stall rises once the front register
// cannot drain into it.
module fire_permission_gate
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic        [fpg_pkg::CfgIdxW-1:0] cfg_index,
    input  logic        [fpg_pkg::CfgDataW-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               control_on,
    input  logic                               has_target,
    input  logic signed [fpg_pkg::YawW-1:0]    command_yaw,
    input  logic signed [fpg_pkg::YawW-1:0]    gimbal_yaw,
    input  logic signed [fpg_pkg::PosW-1:0]    pos_x,
    input  logic signed [fpg_pkg::PosW-1:0]    pos_y,
    input  logic        [fpg_pkg::IdW-1:0]     target_id,
    input  logic                               aim_valid,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               fire
);

    // config registers
    logic                          shoot_en_reg;
    logic                          holdoff_en_reg;
    logic [fpg_pkg::FrameW-1:0]    holdoff_frames_reg;
    logic [fpg_pkg::TolW-1:0]      near_tol_reg;
    logic [fpg_pkg::TolW-1:0]      far_tol_reg;
    logic [fpg_pkg::DistW-1:0]     judge_dist_reg;
    logic [fpg_pkg::Judge2W-1:0]   judge2_reg;
    logic [fpg_pkg::Judge2W-1:0]   judge_ext;

    fpg_pkg::front_cfg_t           front_cfg;
    fpg_pkg::back_cfg_t            back_cfg;

    logic                          q_push;
    logic                          q_pop;
    logic                          q_empty;
    logic                          q_full;
    fpg_pkg::work_t                q_push_word;
    fpg_pkg::work_t                q_pop_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shoot_en_reg       <= 1'b0;
            holdoff_en_reg     <= 1'b0;
            holdoff_frames_reg <= fpg_pkg::HOLDOFF_RESET;
            near_tol_reg       <= '0;
            far_tol_reg        <= '0;
            judge_dist_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpg_pkg::CFG_SHOOT_EN:       shoot_en_reg       <= cfg_data[0];
                fpg_pkg::CFG_HOLDOFF_EN:     holdoff_en_reg     <= cfg_data[0];
                fpg_pkg::CFG_HOLDOFF_FRAMES:
                    holdoff_frames_reg <= cfg_data[fpg_pkg::FrameW-1:0];
                fpg_pkg::CFG_NEAR_TOL:       near_tol_reg <= cfg_data[fpg_pkg::TolW-1:0];
                fpg_pkg::CFG_FAR_TOL:        far_tol_reg  <= cfg_data[fpg_pkg::TolW-1:0];
                fpg_pkg::CFG_JUDGE_DIST:
                    judge_dist_reg <= cfg_data[fpg_pkg::DistW-1:0];
                default:                     ;   // unmapped index: ignored
            endcase
        end
    end

    // d^2 kept registered; it settles the cycle after a write, well before
    // any word reaches the back stage
    assign judge_ext = fpg_pkg::Judge2W'(judge_dist_reg);

    always_ff @(posedge clk)
    begin
        judge2_reg <= judge_ext * judge_ext;
    end

    assign front_cfg.shoot_en       = shoot_en_reg;
    assign front_cfg.holdoff_en     = holdoff_en_reg;
    assign front_cfg.holdoff_frames = holdoff_frames_reg;
    assign back_cfg.near_tol        = near_tol_reg;
    assign back_cfg.far_tol         = far_tol_reg;
    assign back_cfg.judge2          = judge2_reg;

    fpg_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (front_cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .control_on  (control_on),
        .has_target  (has_target),
        .command_yaw (command_yaw),
        .gimbal_yaw  (gimbal_yaw),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .target_id   (target_id),
        .aim_valid   (aim_valid),
        .q_full      (q_full),
        .push        (q_push),
        .push_word   (q_push_word)
    );

    fpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .pop_word  (q_pop_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    fpg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg),
        .q_empty   (q_empty),
        .q_word    (q_pop_word),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .fire      (fire)
    );

endmodule

// ----- sv/fpg_front.sv -----
module fpg_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fpg_pkg::front_cfg_t              cfg,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             control_on,
    input  logic                             has_target,
    input  logic signed [fpg_pkg::YawW-1:0]  command_yaw,
    input  logic signed [fpg_pkg::YawW-1:0]  gimbal_yaw,
    input  logic signed [fpg_pkg::PosW-1:0]  pos_x,
    input  logic signed [fpg_pkg::PosW-1:0]  pos_y,
    input  logic        [fpg_pkg::IdW-1:0]   target_id,
    input  logic                             aim_valid,
    input  logic                             q_full,
    output logic                             push,
    output fpg_pkg::work_t                   push_word
);

    logic                                fr_valid_reg;
    logic                                fr_valid_next;
    fpg_pkg::work_t                      fr_word_reg;
    fpg_pkg::work_t                      fr_word_next;
    logic signed [fpg_pkg::YawW-1:0]     previous_yaw_reg;
    logic        [fpg_pkg::IdW-1:0]      previous_id_reg;
    logic        [fpg_pkg::IdW-1:0]      previous_id_next;
    logic                                previous_id_valid_reg;
    logic                                previous_id_valid_next;
    logic        [fpg_pkg::FrameW-1:0]   holdoff_count_reg;
    logic        [fpg_pkg::FrameW-1:0]   holdoff_count_next;

    logic                                accept;
    logic                                gate_closed;
    logic        [fpg_pkg::FrameW-1:0]   count;
    logic signed [fpg_pkg::DiffW-1:0]    dcmd_s;
    logic signed [fpg_pkg::DiffW-1:0]    dgim_s;
    logic signed [2*fpg_pkg::PosW-1:0]   x2_full;
    logic signed [2*fpg_pkg::PosW-1:0]   y2_full;
    logic                                kill;

    assign in_stall  = fr_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = fr_valid_reg && !q_full;
    assign push_word = fr_word_reg;

    assign gate_closed = !control_on || !has_target || !cfg.shoot_en;

    assign dcmd_s  = {previous_yaw_reg[fpg_pkg::YawW-1], previous_yaw_reg}
                   - {command_yaw[fpg_pkg::YawW-1], command_yaw};
    assign dgim_s  = {gimbal_yaw[fpg_pkg::YawW-1], gimbal_yaw}
                   - {previous_yaw_reg[fpg_pkg::YawW-1], previous_yaw_reg};
    assign x2_full = pos_x * pos_x;
    assign y2_full = pos_y * pos_y;

    // switch detection and hold-off countdown
    always_comb
    begin
        count                  = holdoff_count_reg;
        kill                   = 1'b0;
        previous_id_next       = target_id;
        previous_id_valid_next = 1'b1;
        holdoff_count_next     = '0;
        if (gate_closed)
        begin
            kill                   = 1'b1;
            previous_id_next       = previous_id_reg;
            previous_id_valid_next = 1'b0;
        end
        else if (cfg.holdoff_en)
        begin
            if (previous_id_valid_reg && (target_id != previous_id_reg))
            begin
                count = cfg.holdoff_frames;
            end
            if (count != '0)
            begin
                holdoff_count_next = count - 1'b1;
                kill               = 1'b1;
            end
        end
    end

    always_comb
    begin
        fr_word_next.kill      = kill;
        fr_word_next.aim_valid = aim_valid;
        fr_word_next.x2        = x2_full[fpg_pkg::SqW-1:0];
        fr_word_next.y2        = y2_full[fpg_pkg::SqW-1:0];
        fr_word_next.dcmd      = dcmd_s[fpg_pkg::DiffW-1] ? fpg_pkg::DiffW'(-dcmd_s)
                                                          : fpg_pkg::DiffW'(dcmd_s);
        fr_word_next.dgim      = dgim_s[fpg_pkg::DiffW-1] ? fpg_pkg::DiffW'(-dgim_s)
                                                          : fpg_pkg::DiffW'(dgim_s);
    end

    assign fr_valid_next = accept ? 1'b1 : (push ? 1'b0 : fr_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg          <= 1'b0;
            previous_yaw_reg      <= '0;
            previous_id_reg       <= '0;
            previous_id_valid_reg <= 1'b0;
            holdoff_count_reg     <= '0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
            if (accept)
            begin
                previous_yaw_reg      <= command_yaw;
                previous_id_reg       <= previous_id_next;
                previous_id_valid_reg <= previous_id_valid_next;
                holdoff_count_reg     <= holdoff_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_word_reg <= fr_word_next;
        end
    end

endmodule

// ----- sv/fpg_queue.sv -----
module fpg_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpg_pkg::work_t push_word,
    input  logic           pop,
    output fpg_pkg::work_t pop_word,
    output logic           empty,
    output logic           full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    fpg_pkg::work_t  mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FullCnt);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- sv/fpg_back.sv -----
module fpg_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  fpg_pkg::back_cfg_t  cfg,
    input  logic                q_empty,
    input  fpg_pkg::work_t      q_word,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                fire
);

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         fire_reg;
    logic                         fire_next;
    logic [fpg_pkg::Dist2W-1:0]   dist2;
    logic                         far;
    logic                         near_ok;
    logic                         far_ok;

    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    assign dist2 = fpg_pkg::Dist2W'(q_word.x2) + fpg_pkg::Dist2W'(q_word.y2);
    assign far   = dist2 > fpg_pkg::Dist2W'(cfg.judge2);

    // both tolerance checks in parallel with the distance compare
    assign near_ok = (q_word.dcmd < fpg_pkg::DiffW'({cfg.near_tol, 1'b0}))
                  && (q_word.dgim < fpg_pkg::DiffW'(cfg.near_tol));
    assign far_ok  = (q_word.dcmd < fpg_pkg::DiffW'({cfg.far_tol, 1'b0}))
                  && (q_word.dgim < fpg_pkg::DiffW'(cfg.far_tol));

    assign fire_next = !q_word.kill && q_word.aim_valid && (far ? far_ok : near_ok);

    assign out_valid_next = pop ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fire_reg <= fire_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire      = fire_reg;

endmodule

// ----- sv/fpg_checker.sv -----
`include "fire_permission_gate_defines.svh"

module fpg_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic fire
);

    // stalled result word holds
    `FPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(fire))

    // input backs up only when the queue is full, which needs a waiting result
    `FPG_ASSERT_IMPL(a_stall_has_out, in_stall, out_valid)

    // a new input stall follows a word taken the cycle before
    `FPG_ASSERT_IMPL(a_stall_rise, $rose(in_stall), $past(in_valid && !in_stall))

endmodule

bind fire_permission_gate fpg_checker u_fpg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .fire      (fire)
);

// ----- dv/tb_top.sv -----
module tb_top;

    // one control frame as it crosses the input channel
    typedef struct {
        logic                            control_on;
        logic                            has_target;
        logic signed [fpg_pkg::YawW-1:0] cmd;
        logic signed [fpg_pkg::YawW-1:0] gim;
        logic signed [fpg_pkg::PosW-1:0] x;
        logic signed [fpg_pkg::PosW-1:0] y;
        logic [fpg_pkg::IdW-1:0]         id;
        logic                            aim;
    } frame_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [fpg_pkg::CfgIdxW-1:0]     cfg_index = '0;
    logic [fpg_pkg::CfgDataW-1:0]    cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            control_on = 1'b0;
    logic                            has_target = 1'b0;
    logic signed [fpg_pkg::YawW-1:0] command_yaw = '0;
    logic signed [fpg_pkg::YawW-1:0] gimbal_yaw = '0;
    logic signed [fpg_pkg::PosW-1:0] pos_x = '0;
    logic signed [fpg_pkg::PosW-1:0] pos_y = '0;
    logic [fpg_pkg::IdW-1:0]         target_id = '0;
    logic                            aim_valid = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            fire;

    // register copies seen by the predictor
    logic                       m_auto;
    logic                       m_hold_en;
    logic [fpg_pkg::FrameW-1:0] m_frames;
    logic [fpg_pkg::TolW-1:0]   m_near;
    logic [fpg_pkg::TolW-1:0]   m_far;
    logic [fpg_pkg::DistW-1:0]  m_judge;

    // tracked state: yaw of the last frame, id memory, hold-off counter
    logic signed [fpg_pkg::YawW-1:0] trk_yaw;
    logic [fpg_pkg::IdW-1:0]         trk_id;
    logic                            trk_id_ok;
    logic [fpg_pkg::FrameW-1:0]      trk_hold;

    // sender side memory used to build well-formed yaw walks
    logic signed [fpg_pkg::YawW-1:0] last_cmd = '0;
    logic [fpg_pkg::IdW-1:0]         last_id = '0;

    logic expected_fire [$];
    logic want;
    int   fail_count = 0;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    int   rx_hold_cycles = 0;

    fire_permission_gate dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .control_on (control_on),
        .has_target (has_target),
        .command_yaw(command_yaw),
        .gimbal_yaw (gimbal_yaw),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .target_id  (target_id),
        .aim_valid  (aim_valid),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .fire       (fire)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fire decision for one accepted frame; advances the tracked state.
    function automatic logic decide_fire(input frame_t f);
        longint prev, dcmd, dgim, d2, j2, tol;
        prev = longint'(trk_yaw);
        trk_yaw = f.cmd;   // yaw memory moves on every frame
        if (!f.control_on || !f.has_target || !m_auto)
        begin
            trk_id_ok = 1'b0;
            trk_hold  = '0;
            return 1'b0;
        end
        // squared compare, exact at 64 bits
        d2  = longint'(f.x) * longint'(f.x) + longint'(f.y) * longint'(f.y);
        j2  = longint'(m_judge) * longint'(m_judge);
        tol = (d2 > j2) ? longint'(m_far) : longint'(m_near);
        if (m_hold_en)
        begin
            if (trk_id_ok && f.id != trk_id)
                trk_hold = m_frames;
            trk_id    = f.id;
            trk_id_ok = 1'b1;
            if (trk_hold > 0)
            begin
                trk_hold = trk_hold - 1'b1;
                return 1'b0;
            end
        end
        else
        begin
            trk_id    = f.id;
            trk_id_ok = 1'b1;
            trk_hold  = '0;
        end
        dcmd = prev - longint'(f.cmd);
        if (dcmd < 0)
            dcmd = -dcmd;
        dgim = longint'(f.gim) - prev;
        if (dgim < 0)
            dgim = -dgim;
        return (dcmd < 2 * tol) && (dgim < tol) && f.aim;
    endfunction

    function automatic frame_t mk_frame(input int c, input int t,
                                        input int cmd, input int gim,
                                        input int x, input int y,
                                        input int id, input int aim);
        frame_t f;
        f.control_on = c[0];
        f.has_target = t[0];
        f.cmd = cmd;
        f.gim = gim;
        f.x   = x[fpg_pkg::PosW-1:0];
        f.y   = y[fpg_pkg::PosW-1:0];
        f.id  = id[fpg_pkg::IdW-1:0];
        f.aim = aim[0];
        return f;
    endfunction

    // uniform in [-m, m]
    function automatic longint rand_pm(input longint m);
        return longint'($urandom_range(0, 32'(2 * m))) - m;
    endfunction

    // Mostly yaw walks near the tolerance window, positions near the origin,
    // inside or at the judge distance, or random; one in ten is raw noise.
    function automatic frame_t next_frame();
        frame_t f;
        longint span, cv, gv, m, xv, yv;
        int shape;
        if ($urandom_range(0, 9) == 0)
        begin
            f.control_on = 1'($urandom);
            f.has_target = 1'($urandom);
            f.cmd = $urandom;
            f.gim = $urandom;
            f.x   = fpg_pkg::PosW'($urandom);
            f.y   = fpg_pkg::PosW'($urandom);
            f.id  = fpg_pkg::IdW'($urandom);
            f.aim = 1'($urandom);
            return f;
        end
        span = $urandom_range(0, 1) ? longint'(m_far) : longint'(m_near);
        cv = longint'(last_cmd) + rand_pm(2 * span + 2);
        gv = longint'(last_cmd) + rand_pm(span + 1);
        f.cmd = cv[fpg_pkg::YawW-1:0];
        f.gim = gv[fpg_pkg::YawW-1:0];
        m = longint'(m_judge);
        shape = $urandom_range(0, 3);
        case (shape)
            0:
            begin
                xv = longint'($urandom);
                yv = longint'($urandom);
            end
            1:
            begin
                xv = rand_pm(m);
                yv = rand_pm(m);
            end
            2:
            begin
                xv = rand_pm(16);
                yv = rand_pm(16);
            end
            default:
            begin
                // on an axis right at the boundary
                xv = ($urandom_range(0, 1) ? m : -m) + rand_pm(2);
                yv = rand_pm(2);
            end
        endcase
        f.x = xv[fpg_pkg::PosW-1:0];
        f.y = yv[fpg_pkg::PosW-1:0];
        f.control_on = ($urandom_range(0, 15) != 0);
        f.has_target = ($urandom_range(0, 15) != 0);
        f.id  = ($urandom_range(0, 99) < 85) ? last_id : fpg_pkg::IdW'($urandom);
        f.aim = ($urandom_range(0, 7) != 0);
        return f;
    endfunction

    // Offer one word; returns at the edge where it is taken.
    task automatic offer_frame(input frame_t f);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        control_on  <= f.control_on;
        has_target  <= f.has_target;
        command_yaw <= f.cmd;
        gimbal_yaw  <= f.gim;
        pos_x       <= f.x;
        pos_y       <= f.y;
        target_id   <= f.id;
        aim_valid   <= f.aim;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        expected_fire.push_back(decide_fire(f));
        last_cmd = f.cmd;
        last_id  = f.id;
    endtask

    // Drop valid and wait until every decision has come back.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_fire.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Writes all six registers back to back; caller makes sure the block is idle.
    task automatic program_regs(input int a, input int h, input int fr,
                                input int nt, input int ft, input int jd);
        logic [fpg_pkg::CfgIdxW-1:0]  idx [6];
        logic [fpg_pkg::CfgDataW-1:0] val [6];
        m_auto    = a[0];
        m_hold_en = h[0];
        m_frames  = fr[fpg_pkg::FrameW-1:0];
        m_near    = nt[fpg_pkg::TolW-1:0];
        m_far     = ft[fpg_pkg::TolW-1:0];
        m_judge   = jd[fpg_pkg::DistW-1:0];
        idx = '{fpg_pkg::CFG_SHOOT_EN, fpg_pkg::CFG_HOLDOFF_EN, fpg_pkg::CFG_HOLDOFF_FRAMES,
                fpg_pkg::CFG_NEAR_TOL, fpg_pkg::CFG_FAR_TOL, fpg_pkg::CFG_JUDGE_DIST};
        val = '{fpg_pkg::CfgDataW'(m_auto), fpg_pkg::CfgDataW'(m_hold_en),
                fpg_pkg::CfgDataW'(m_frames), fpg_pkg::CfgDataW'(m_near),
                fpg_pkg::CfgDataW'(m_far), fpg_pkg::CfgDataW'(m_judge)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
    endtask

    // Reset config has shooting disabled: a fully armed frame must not fire.
    task automatic test_shoot_disabled();
        offer_frame(mk_frame(1, 1, 0, 0, 0, 0, 0, 1));
        settle_idle();
    endtask

    // Near/far choice, aim, id switch hold-off, gate closing, yaw extremes.
    task automatic test_directed();
        program_regs(1, 1, 2, 1000, 200, 5000);
        offer_frame(mk_frame(1, 1, 100, 100, 100, 100, 5, 1));   // first target, fires
        offer_frame(mk_frame(1, 1, 100, 100, 100, 100, 5, 0));   // aim not valid
        offer_frame(mk_frame(1, 1, 100, 100, 8388607, -8388608, 5, 1)); // far corner
        offer_frame(mk_frame(1, 1, 100, 100, 0, 0, 6, 1));       // switch: blocked
        offer_frame(mk_frame(1, 1, 100, 100, 0, 0, 6, 1));       // still blocked
        offer_frame(mk_frame(1, 1, 100, 100, 0, 0, 6, 1));       // hold-off over
        offer_frame(mk_frame(0, 1, 100, 100, 0, 0, 6, 1));       // no control
        offer_frame(mk_frame(1, 0, 100, 100, 0, 0, 7, 1));       // no target
        offer_frame(mk_frame(1, 1, 100, 100, 0, 0, 255, 1));     // new id after closed gate
        offer_frame(mk_frame(1, 1, 100, 600, 3000, 4000, 255, 1)); // exactly at judge: near
        offer_frame(mk_frame(1, 1, 100, 600, 3000, 4001, 255, 1)); // just past: far
        offer_frame(mk_frame(1, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 255, 1));
        offer_frame(mk_frame(1, 1, 32'sh80000000, 32'sh80000000, 0, 0, 255, 1)); // no wrap
        offer_frame(mk_frame(1, 1, 32'sh80000000, 32'sh80000000 + 999, 0, 0, 255, 1));
        // command step just inside 2*tol, gimbal exactly at tol
        offer_frame(mk_frame(1, 1, 32'sh80000000 + 1999, 32'sh80000000 + 1000, 0, 0, 255, 1));
        offer_frame(mk_frame(1, 1, 32'sh80000000 + 1999, 32'sh80000000 + 1999, 0, 0, 0, 1));
        settle_idle();
    endtask

    // Hold-off disabled, then enabled with zero frames: id changes block nothing.
    task automatic test_holdoff_modes();
        program_regs(1, 0, 2, 1000, 200, 5000);
        offer_frame(mk_frame(1, 1, 0, 0, 10, 10, 1, 1));
        offer_frame(mk_frame(1, 1, 0, 0, 10, 10, 2, 1));
        offer_frame(mk_frame(1, 1, 0, 0, 10, 10, 3, 1));
        settle_idle();
        program_regs(1, 1, 0, 1000, 200, 5000);
        offer_frame(mk_frame(1, 1, 0, 0, 10, 10, 4, 1));
        offer_frame(mk_frame(1, 1, 0, 0, 10, 10, 5, 1));
        settle_idle();
    endtask

    // Long output stall with back-to-back input so the queue fills and
    // in_stall rises; then a full drain before the next burst.
    task automatic test_backpressure();
        program_regs(1, 1, 3, 50000, 20000, 100000);
        tx_idle_on = 1'b0;
        rx_hold_cycles = 40;
        repeat (30) offer_frame(next_frame());
        settle_idle();
        tx_idle_on = 1'b1;
        rx_hold_cycles = 25;
        repeat (20) offer_frame(next_frame());
        settle_idle();
    endtask

    // Random frames over several register settings, extremes included.
    task automatic test_random_sweep();
        int cnt;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: program_regs(1, 1, 3, 2000, 300, 3000);
                1: program_regs(1, 1, 0, 0, 0, 0);
                2: program_regs(1, 1, 255, 'hFFFFF, 'hFFFFF, 'h7FFFFF);
                3: program_regs(0, $urandom, $urandom, $urandom, $urandom, $urandom);
                default:
                    program_regs(int'($urandom_range(0, 7) != 0), $urandom,
                                 $urandom_range(0, 6),
                                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000),
                                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000),
                                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000));
            endcase
            cnt = (ph == 3) ? 60 : (ph == 2) ? 100 : 140;
            for (int k = 0; k < cnt; k++)
            begin
                // stretches with and without idling on either side
                if (k % 40 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 199) == 0)
                    settle_idle();
                offer_frame(next_frame());
            end
            settle_idle();
        end
    endtask

    // Receiver: random stall before each word, or a long hold on request.
    initial
    begin : receiver
        int n;
        forever
        begin
            n = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1 && rx_hold_cycles == 0);
        end
    end

    // Compare each taken word with the oldest pending decision.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_fire.size() == 0)
            begin
                $error("fire: word with nothing expected, actual %0b", fire);
                fail_count++;
            end
            else
            begin
                want = expected_fire.pop_front();
                if (fire !== want)
                begin
                    $error("fire mismatch: expected %0b, actual %0b", want, fire);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : main
        int n;
        m_auto    = 1'b0;
        m_hold_en = 1'b0;
        m_frames  = fpg_pkg::HOLDOFF_RESET;
        m_near    = '0;
        m_far     = '0;
        m_judge   = '0;
        trk_yaw   = '0;
        trk_id    = '0;
        trk_id_ok = 1'b0;
        trk_hold  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_shoot_disabled();
        test_directed();
        test_holdoff_modes();
        test_backpressure();
        test_random_sweep();

        in_valid <= 1'b0;
        for (n = 0; n < 20000 && expected_fire.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_fire.size() != 0)
        begin
            $error("fire: %0d decisions never arrived", expected_fire.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #5000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/fpg_pkg.sv
sv/fpg_front.sv
sv/fpg_queue.sv
sv/fpg_back.sv
sv/fire_permission_gate.sv
sv/fpg_checker.sv
dv/tb_top.sv
